// ----- rtl/pmsm_pkg.sv -----
// Shared types and codes of the point model similarity merge block.
package pmsm_pkg;

	localparam logic [2:0] MODE_APOS = 3'd0;
	localparam logic [2:0] MODE_AROT = 3'd1;
	localparam logic [2:0] MODE_CROT = 3'd2;
	localparam logic [2:0] MODE_RROT = 3'd3;
	localparam logic [2:0] MODE_VPOS = 3'd4;
	localparam logic [2:0] MODE_FEAT = 3'd5;

	localparam logic [1:0] KIND_FEAT = 2'd0;
	localparam logic [1:0] KIND_POS  = 2'd1;
	localparam logic [1:0] KIND_ROT  = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSCALE = 2'd1;
	localparam logic [1:0] STAT_SAT     = 2'd2;

	typedef enum logic [2:0] {
		OP_P0, OP_P1, OP_AROT, OP_CROT, OP_RROT, OP_VIEW, OP_FEAT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_NORM, ST_SQRT, ST_DIV, ST_OFFS, ST_XSTART,
		ST_SCALE, ST_ROT, ST_POUT, ST_CHAIN, ST_COUT
	} state_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [1:0]         row;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         out_row;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	typedef struct packed {
		op_t                op;
		logic [1:0]         row;
		logic               first;
		logic               second;
		logic               emit;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cmd_t;

endpackage

// ----- rtl/pmsm_front.sv -----
// Front end: accepts input words, tracks the viewpoint index and classifies each word.
module pmsm_front #(
	parameter int MAX_VIEWPOINTS = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pmsm_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [3:0]    cfg_data,
	output logic          push,
	output pmsm_pkg::cmd_t cmd,
	input  logic          full
);
	import pmsm_pkg::*;

	localparam int VW = $clog2(MAX_VIEWPOINTS + 1);
	localparam int CW = (VW > 4) ? VW : 4;

	logic [VW-1:0] vcnt_q;
	logic [3:0]    ccount_q;
	logic          keep;
	logic          acc;

	always_comb begin
		keep = 1'b0;
		cmd.op = OP_FEAT;
		case (req.mode)
			MODE_APOS: begin
				if (req.row == 2'd0) begin
					keep = 1'b1;
					cmd.op = OP_P0;
				end else if (req.row == 2'd1) begin
					keep = 1'b1;
					cmd.op = OP_P1;
				end
			end
			MODE_AROT: begin
				keep = (req.row != 2'd3);
				cmd.op = OP_AROT;
			end
			MODE_CROT: begin
				keep = (req.row != 2'd3);
				cmd.op = OP_CROT;
			end
			MODE_RROT: begin
				keep = (req.row != 2'd3);
				cmd.op = OP_RROT;
			end
			MODE_VPOS: begin
				keep = 1'b1;
				cmd.op = OP_VIEW;
			end
			MODE_FEAT: begin
				keep = 1'b1;
				cmd.op = OP_FEAT;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		cmd.row = req.row;
		cmd.first = (vcnt_q == '0);
		cmd.second = (vcnt_q == VW'(1));
		cmd.emit = (CW'(vcnt_q) >= CW'(ccount_q));
		cmd.x = req.x;
		cmd.y = req.y;
		cmd.z = req.z;
	end

	assign req_stall = full;
	assign acc = req_valid && !full;
	assign push = acc && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			ccount_q <= 4'd2;
		end else begin
			if (cfg_we) begin
				ccount_q <= cfg_data;
			end
			if (push && cmd.op == OP_P0) begin
				vcnt_q <= '0;
			end else if (push && cmd.op == OP_VIEW && vcnt_q != VW'(MAX_VIEWPOINTS)) begin
				vcnt_q <= vcnt_q + VW'(1);
			end
		end
	end

endmodule

// ----- rtl/pmsm_fifo.sv -----
// Two-entry queue of classified words between the front and back ends.
module pmsm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pmsm_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output pmsm_pkg::cmd_t rdata
);
	import pmsm_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/pmsm_back.sv -----
// Back end: sequencer with one shared multiplier, square root and divider units.
module pmsm_back #(
	parameter int COORD_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  pmsm_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pmsm_pkg::rsp_t rsp
);
	import pmsm_pkg::*;

	localparam int PW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
	localparam logic signed [71:0] PMAX = (72'sd1 <<< (PW - 1)) - 72'sd1;
	localparam logic signed [71:0] PMIN = -PMAX - 72'sd1;
	localparam logic signed [71:0] RMAX = 72'sd2147483647;
	localparam logic signed [71:0] RMIN = -RMAX - 72'sd1;

	function automatic logic [32:0] clipw(input logic signed [71:0] v,
		input logic signed [71:0] hi, input logic signed [71:0] lo);
		logic [32:0] r;
		if (v > hi) begin
			r = {1'b1, hi[31:0]};
		end else if (v < lo) begin
			r = {1'b1, lo[31:0]};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic [3:0] mi(input logic [1:0] r, input logic [1:0] k);
		return 4'(r) * 4'd3 + 4'(k);
	endfunction

	state_t state_q, state_d;
	cmd_t   cur_q;

	logic signed [31:0] p0_q [3];
	logic signed [31:0] p1_q [3];
	logic signed [31:0] q0_q [3];
	logic signed [31:0] off_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] sv_q [3];
	logic signed [31:0] res_q [3];
	logic signed [31:0] nrow_q [3];
	logic signed [31:0] ar_q [9];
	logic signed [31:0] cr_q [9];
	logic signed [31:0] rel_q [9];
	logic [31:0] scale_q;
	logic        ready_q, oclip_q, sat_q, rsat_q, nsel_q, ph_q;
	logic [63:0] sum_q, rad_q;
	logic [31:0] root_q, nq_q;
	logic [33:0] rem_q;
	logic [47:0] dvd_q;
	logic [32:0] drem_q;
	logic [5:0]  it_q;
	logic [1:0]  ri_q, ci_q, ki_q;
	logic signed [39:0] acc_q;
	logic signed [67:0] prod_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic signed [33:0] ma, mb;
	logic signed [67:0] prod_d;
	logic signed [32:0] dn;
	logic [32:0] mag;
	logic [31:0] hm;
	logic signed [71:0] pw, r16, r30;
	logic signed [39:0] acc_in, acc_new;
	logic [35:0] rem2, trial;
	logic [31:0] root_new;
	logic [33:0] drem2;
	logic        qbit;
	logic        out_free, emit;
	rsp_t        ow;
	logic [32:0] c_off, c_sv, c_pos, c_rot;

	always_comb begin
		dn = nsel_q ? ({p1_q[ki_q][31], p1_q[ki_q]} - {p0_q[ki_q][31], p0_q[ki_q]})
			: ({v_q[ki_q][31], v_q[ki_q]} - {q0_q[ki_q][31], q0_q[ki_q]});
		mag = dn[32] ? 33'(-dn) : 33'(dn);
		hm = mag[32:1];
		ma = '0;
		mb = '0;
		case (state_q)
			ST_NORM: begin
				ma = {2'b00, hm};
				mb = {2'b00, hm};
			end
			ST_OFFS: begin
				ma = {{2{q0_q[ki_q][31]}}, q0_q[ki_q]};
				mb = {2'b00, scale_q};
			end
			ST_SCALE: begin
				ma = {{2{v_q[ki_q][31]}}, v_q[ki_q]};
				mb = {2'b00, scale_q};
			end
			ST_ROT: begin
				ma = {{2{ar_q[mi(ri_q, ki_q)][31]}}, ar_q[mi(ri_q, ki_q)]};
				mb = {{2{sv_q[ki_q][31]}}, sv_q[ki_q]};
			end
			ST_CHAIN: begin
				ma = {{2{cr_q[mi(ri_q, ki_q)][31]}}, cr_q[mi(ri_q, ki_q)]};
				mb = {{2{rel_q[mi(ci_q, ki_q)][31]}}, rel_q[mi(ci_q, ki_q)]};
			end
			default: begin
				ma = '0;
			end
		endcase
		prod_d = ma * mb;

		pw = {{4{prod_q[67]}}, prod_q};
		r16 = (pw + 72'sd32768) >>> 16;
		r30 = (pw + 72'sd536870912) >>> 30;
		if (state_q == ST_ROT) begin
			acc_in = (ki_q == 2'd0) ? {{8{off_q[ri_q][31]}}, off_q[ri_q]} : acc_q;
		end else begin
			acc_in = (ki_q == 2'd0) ? 40'sd0 : acc_q;
		end
		acc_new = acc_in + r30[39:0];
		c_off = clipw({{40{p0_q[ki_q][31]}}, p0_q[ki_q]} - r16, PMAX, PMIN);
		c_sv = clipw(r16, PMAX, PMIN);
		c_pos = clipw({{32{acc_new[39]}}, acc_new}, PMAX, PMIN);
		c_rot = clipw({{32{acc_new[39]}}, acc_new}, RMAX, RMIN);

		rem2 = {rem_q, rad_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		root_new = {root_q[30:0], (rem2 >= trial)};
		drem2 = {drem_q, dvd_q[47]};
		qbit = (drem2 >= {2'b00, nq_q});
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		emit = 1'b0;
		ow = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd.op == OP_FEAT) begin
						state_d = ST_XSTART;
					end else if (q_cmd.op == OP_VIEW) begin
						if (q_cmd.second) begin
							state_d = ST_NORM;
						end else if (q_cmd.emit) begin
							state_d = ST_XSTART;
						end
					end
				end
			end
			ST_NORM: begin
				if (ph_q && ki_q == 2'd2) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (it_q == 6'd31) begin
					if (!nsel_q) begin
						state_d = ST_NORM;
					end else if (nq_q != '0) begin
						state_d = ST_DIV;
					end else begin
						state_d = cur_q.emit ? ST_XSTART : ST_IDLE;
					end
				end
			end
			ST_DIV: begin
				if (it_q == 6'd47) begin
					state_d = ST_OFFS;
				end
			end
			ST_OFFS: begin
				if (ph_q && ki_q == 2'd2) begin
					state_d = cur_q.emit ? ST_XSTART : ST_IDLE;
				end
			end
			ST_XSTART: begin
				state_d = ready_q ? ST_SCALE : ST_POUT;
			end
			ST_SCALE: begin
				if (ph_q && ki_q == 2'd2) begin
					state_d = ST_ROT;
				end
			end
			ST_ROT: begin
				if (ph_q && ki_q == 2'd2 && ri_q == 2'd2) begin
					state_d = ST_POUT;
				end
			end
			ST_POUT: begin
				if (out_free) begin
					emit = 1'b1;
					ow.kind = (cur_q.op == OP_FEAT) ? KIND_FEAT : KIND_POS;
					ow.out_x = ready_q ? res_q[0] : 32'sd0;
					ow.out_y = ready_q ? res_q[1] : 32'sd0;
					ow.out_z = ready_q ? res_q[2] : 32'sd0;
					ow.status = !ready_q ? STAT_NOSCALE : (sat_q ? STAT_SAT : STAT_OK);
					ow.last = (cur_q.op == OP_FEAT);
					state_d = (cur_q.op == OP_FEAT) ? ST_IDLE : ST_CHAIN;
				end
			end
			ST_CHAIN: begin
				if (ph_q && ki_q == 2'd2 && ci_q == 2'd2) begin
					state_d = ST_COUT;
				end
			end
			ST_COUT: begin
				if (out_free) begin
					emit = 1'b1;
					ow.kind = KIND_ROT;
					ow.out_row = ri_q;
					ow.out_x = nrow_q[0];
					ow.out_y = nrow_q[1];
					ow.out_z = nrow_q[2];
					ow.status = rsat_q ? STAT_SAT : STAT_OK;
					ow.last = (ri_q == 2'd2);
					state_d = (ri_q == 2'd2) ? ST_IDLE : ST_CHAIN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			for (int i = 0; i < 3; i++) begin
				p0_q[i] <= '0;
				p1_q[i] <= '0;
				q0_q[i] <= '0;
				off_q[i] <= '0;
				v_q[i] <= '0;
				sv_q[i] <= '0;
				res_q[i] <= '0;
				nrow_q[i] <= '0;
			end
			for (int i = 0; i < 9; i++) begin
				ar_q[i] <= '0;
				cr_q[i] <= '0;
				rel_q[i] <= '0;
			end
			scale_q <= '0;
			ready_q <= 1'b0;
			oclip_q <= 1'b0;
			sat_q <= 1'b0;
			rsat_q <= 1'b0;
			nsel_q <= 1'b0;
			ph_q <= 1'b0;
			sum_q <= '0;
			rad_q <= '0;
			root_q <= '0;
			nq_q <= '0;
			rem_q <= '0;
			dvd_q <= '0;
			drem_q <= '0;
			it_q <= '0;
			ri_q <= '0;
			ci_q <= '0;
			ki_q <= '0;
			acc_q <= '0;
			prod_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_cmd;
						v_q[0] <= q_cmd.x;
						v_q[1] <= q_cmd.y;
						v_q[2] <= q_cmd.z;
						ki_q <= '0;
						ph_q <= 1'b0;
						nsel_q <= 1'b0;
						sum_q <= '0;
						case (q_cmd.op)
							OP_P0: begin
								p0_q[0] <= q_cmd.x;
								p0_q[1] <= q_cmd.y;
								p0_q[2] <= q_cmd.z;
								ready_q <= 1'b0;
								scale_q <= '0;
								oclip_q <= 1'b0;
								for (int i = 0; i < 3; i++) begin
									off_q[i] <= '0;
								end
							end
							OP_P1: begin
								p1_q[0] <= q_cmd.x;
								p1_q[1] <= q_cmd.y;
								p1_q[2] <= q_cmd.z;
							end
							OP_AROT: begin
								ar_q[mi(q_cmd.row, 2'd0)] <= q_cmd.x;
								ar_q[mi(q_cmd.row, 2'd1)] <= q_cmd.y;
								ar_q[mi(q_cmd.row, 2'd2)] <= q_cmd.z;
							end
							OP_CROT: begin
								cr_q[mi(q_cmd.row, 2'd0)] <= q_cmd.x;
								cr_q[mi(q_cmd.row, 2'd1)] <= q_cmd.y;
								cr_q[mi(q_cmd.row, 2'd2)] <= q_cmd.z;
							end
							OP_RROT: begin
								rel_q[mi(q_cmd.row, 2'd0)] <= q_cmd.x;
								rel_q[mi(q_cmd.row, 2'd1)] <= q_cmd.y;
								rel_q[mi(q_cmd.row, 2'd2)] <= q_cmd.z;
							end
							OP_VIEW: begin
								if (q_cmd.first) begin
									q0_q[0] <= q_cmd.x;
									q0_q[1] <= q_cmd.y;
									q0_q[2] <= q_cmd.z;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_NORM: begin
					ph_q <= !ph_q;
					if (!ph_q) begin
						prod_q <= prod_d;
					end else begin
						sum_q <= sum_q + prod_q[63:0];
						ki_q <= (ki_q == 2'd2) ? 2'd0 : ki_q + 2'd1;
						if (ki_q == 2'd2) begin
							rad_q <= sum_q + prod_q[63:0];
							rem_q <= '0;
							root_q <= '0;
							it_q <= '0;
						end
					end
				end
				ST_SQRT: begin
					rem_q <= (rem2 >= trial) ? 34'(rem2 - trial) : rem2[33:0];
					root_q <= root_new;
					rad_q <= {rad_q[61:0], 2'b00};
					it_q <= (it_q == 6'd31 && nsel_q && nq_q != '0) ? 6'd0 : it_q + 6'd1;
					if (it_q == 6'd31) begin
						if (!nsel_q) begin
							nq_q <= root_new;
							nsel_q <= 1'b1;
							sum_q <= '0;
							ki_q <= '0;
							ph_q <= 1'b0;
						end else if (nq_q == '0) begin
							ready_q <= 1'b0;
							scale_q <= '0;
						end else begin
							dvd_q <= {root_new, 16'd0};
							drem_q <= '0;
						end
					end
				end
				ST_DIV: begin
					drem_q <= qbit ? 33'(drem2 - {2'b00, nq_q}) : drem2[32:0];
					dvd_q <= {dvd_q[46:0], qbit};
					it_q <= it_q + 6'd1;
					if (it_q == 6'd47) begin
						scale_q <= (dvd_q[46:31] != '0) ? 32'hFFFF_FFFF
							: {dvd_q[30:0], qbit};
						oclip_q <= 1'b0;
						ki_q <= '0;
						ph_q <= 1'b0;
					end
				end
				ST_OFFS: begin
					ph_q <= !ph_q;
					if (!ph_q) begin
						prod_q <= prod_d;
					end else begin
						off_q[ki_q] <= c_off[31:0];
						if (c_off[32]) begin
							oclip_q <= 1'b1;
						end
						ki_q <= (ki_q == 2'd2) ? 2'd0 : ki_q + 2'd1;
						if (ki_q == 2'd2) begin
							ready_q <= 1'b1;
						end
					end
				end
				ST_XSTART: begin
					sat_q <= oclip_q;
					ki_q <= '0;
					ri_q <= '0;
					ph_q <= 1'b0;
				end
				ST_SCALE: begin
					ph_q <= !ph_q;
					if (!ph_q) begin
						prod_q <= prod_d;
					end else begin
						sv_q[ki_q] <= c_sv[31:0];
						if (c_sv[32]) begin
							sat_q <= 1'b1;
						end
						ki_q <= (ki_q == 2'd2) ? 2'd0 : ki_q + 2'd1;
					end
				end
				ST_ROT: begin
					ph_q <= !ph_q;
					if (!ph_q) begin
						prod_q <= prod_d;
					end else if (ki_q != 2'd2) begin
						acc_q <= acc_new;
						ki_q <= ki_q + 2'd1;
					end else begin
						res_q[ri_q] <= c_pos[31:0];
						if (c_pos[32]) begin
							sat_q <= 1'b1;
						end
						ki_q <= '0;
						ri_q <= (ri_q == 2'd2) ? 2'd0 : ri_q + 2'd1;
					end
				end
				ST_POUT: begin
					if (out_free) begin
						ri_q <= '0;
						ci_q <= '0;
						ki_q <= '0;
						ph_q <= 1'b0;
						rsat_q <= 1'b0;
					end
				end
				ST_CHAIN: begin
					ph_q <= !ph_q;
					if (!ph_q) begin
						prod_q <= prod_d;
					end else if (ki_q != 2'd2) begin
						acc_q <= acc_new;
						ki_q <= ki_q + 2'd1;
					end else begin
						nrow_q[ci_q] <= c_rot[31:0];
						if (c_rot[32]) begin
							rsat_q <= 1'b1;
						end
						ki_q <= '0;
						ci_q <= (ci_q == 2'd2) ? 2'd0 : ci_q + 2'd1;
					end
				end
				ST_COUT: begin
					if (out_free) begin
						cr_q[mi(ri_q, 2'd0)] <= nrow_q[0];
						cr_q[mi(ri_q, 2'd1)] <= nrow_q[1];
						cr_q[mi(ri_q, 2'd2)] <= nrow_q[2];
						rsat_q <= 1'b0;
						ri_q <= ri_q + 2'd1;
						ci_q <= '0;
						ki_q <= '0;
						ph_q <= 1'b0;
					end
				end
				default: begin
					ph_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= ow;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ----- rtl/point_model_similarity_merge_core.sv -----
// Top level of the point model similarity merge block.
// The request channel (req_valid, req_stall, req) carries anchor loads, rotation
// rows, viewpoint positions and feature points; a word is taken when req_valid
// is high and req_stall is low. The response channel (rsp_valid, rsp_stall, rsp)
// returns transformed features, new viewpoint positions and chained rotation rows.
// cfg_we with cfg_data sets the count of overlapping viewpoints; it defaults to 2.
// The front end classifies each word into a two-entry queue, so loads are taken
// one per cycle while the queue has room. The back end runs one word at a time
// around a single shared multiplier. A feature returns one result and an emitted
// viewpoint returns four. The second viewpoint first derives the scale with two
// 32-step square roots and a 48-step divide, skipped when the first root is zero.
// Reset clears all anchors, matrices, the scale and the viewpoint count to zero.
// When rsp_stall is high the result register holds its word and the back end
// waits; the queue then fills and req_stall rises.
module point_model_similarity_merge_core #(
	parameter int COORD_WIDTH    = 32,
	parameter int MAX_VIEWPOINTS = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pmsm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pmsm_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_data
);
	import pmsm_pkg::*;

	cmd_t push_cmd, pop_cmd;
	logic push, full, pop, qv;

	pmsm_front #(.MAX_VIEWPOINTS(MAX_VIEWPOINTS)) u_front (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .cfg_we(cfg_we), .cfg_data(cfg_data), .push(push),
		.cmd(push_cmd), .full(full)
	);

	pmsm_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_cmd), .full(full),
		.pop(pop), .valid(qv), .rdata(pop_cmd)
	);

	pmsm_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_cmd(pop_cmd), .q_pop(pop),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

endmodule

// ----- rtl/pmsm_check.sv -----
// Port checker for the response channel, bound to the top level.
module pmsm_check (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input pmsm_pkg::rsp_t rsp
);
	import pmsm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response word changed.");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3)
		else $error("Response status out of range.");

	a_feat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_FEAT |-> rsp.last && rsp.out_row == 2'd0)
		else $error("Feature word must be last with row zero.");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_POS |-> !rsp.last && rsp.status != STAT_SAT
			|| rsp_valid && rsp.kind == KIND_POS && !rsp.last)
		else $error("Viewpoint position word must not be last.");

	a_rot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_ROT |-> rsp.out_row != 2'd3
			&& rsp.status != STAT_NOSCALE && (rsp.last == (rsp.out_row == 2'd2)))
		else $error("Rotation row word malformed.");

endmodule

bind point_model_similarity_merge_core pmsm_check u_check (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
